// File: sv/q2e_pkg.sv
// Shared widths, types and constants for the quaternion to Euler angle core.
package q2e_pkg;

  localparam int InW       = 16;
  localparam int ProdW     = 2 * InW;
  localparam int TermW     = 35;
  localparam int NumW      = 58;
  localparam int RootW     = 29;
  localparam int RemW      = 32;
  localparam int SqrtCells = NumW / 2;
  localparam int CordW     = 38;
  localparam int AngW      = 26;
  localparam int CordIters = 20;
  localparam int ShiftW    = 5;
  localparam int OutW      = 16;
  localparam int NumStages = 3 + SqrtCells + 1 + CordIters + 1;

  localparam logic signed [TermW-1:0] OneQ28  = TermW'(64'sd1 <<< 28);
  localparam logic signed [AngW-1:0]  Deg90   = AngW'(90 * 65536);
  localparam logic signed [AngW-1:0]  Deg90N  = -AngW'(90 * 65536);
  localparam logic [OutW-1:0]         Deg180O = OutW'(23040);
  localparam logic [OutW-1:0]         Deg360O = OutW'(46080);
  localparam logic [OutW-1:0]         Deg270O = OutW'(34560);
  localparam logic [OutW-1:0]         Deg90O  = OutW'(11520);

  typedef logic signed [TermW-1:0] term_t;

  typedef struct packed {
    term_t sinr;
    term_t cosr;
    term_t sinp;
    term_t siny;
    term_t cosy;
    logic  clamp;
  } side_t;

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [AngW-1:0]  z;
    logic                    zero;
  } vec_t;

  function automatic logic signed [AngW-1:0] atan_step(input logic [ShiftW-1:0] i);
    logic signed [AngW-1:0] a;
    unique case (i)
      5'd0:    a = AngW'(2949120);
      5'd1:    a = AngW'(1740967);
      5'd2:    a = AngW'(919879);
      5'd3:    a = AngW'(466945);
      5'd4:    a = AngW'(234379);
      5'd5:    a = AngW'(117304);
      5'd6:    a = AngW'(58666);
      5'd7:    a = AngW'(29335);
      5'd8:    a = AngW'(14668);
      5'd9:    a = AngW'(7334);
      5'd10:   a = AngW'(3667);
      5'd11:   a = AngW'(1833);
      5'd12:   a = AngW'(917);
      5'd13:   a = AngW'(458);
      5'd14:   a = AngW'(229);
      5'd15:   a = AngW'(115);
      5'd16:   a = AngW'(57);
      5'd17:   a = AngW'(29);
      5'd18:   a = AngW'(14);
      5'd19:   a = AngW'(7);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: sv/q2e_if.sv
// Valid/ready channel interfaces for quaternion beats and Euler angle beats.
interface q2e_quat_if;
  logic                          valid;
  logic                          ready;
  logic signed [q2e_pkg::InW-1:0] quat_w;
  logic signed [q2e_pkg::InW-1:0] quat_x;
  logic signed [q2e_pkg::InW-1:0] quat_y;
  logic signed [q2e_pkg::InW-1:0] quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface q2e_euler_if;
  logic                      valid;
  logic                      ready;
  logic [q2e_pkg::OutW-1:0]  roll_deg;
  logic [q2e_pkg::OutW-1:0]  pitch_deg;
  logic [q2e_pkg::OutW-1:0]  yaw_deg;
  logic                      pitch_clamped;
  modport source (output valid, roll_deg, pitch_deg, yaw_deg, pitch_clamped, input ready);
  modport sink   (input valid, roll_deg, pitch_deg, yaw_deg, pitch_clamped, output ready);
endinterface

// File: sv/q2e_sqrt_cell.sv
// One digit cell of the pipelined integer square root, with side data.
module q2e_sqrt_cell (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [q2e_pkg::NumW-1:0]     num_i,
  input  logic [q2e_pkg::RemW-1:0]     rem_i,
  input  logic [q2e_pkg::RootW-1:0]    root_i,
  input  q2e_pkg::side_t               side_i,
  output logic [q2e_pkg::NumW-1:0]     num_o,
  output logic [q2e_pkg::RemW-1:0]     rem_o,
  output logic [q2e_pkg::RootW-1:0]    root_o,
  output q2e_pkg::side_t               side_o
);

  logic [q2e_pkg::RemW-1:0]  rem_sh;
  logic [q2e_pkg::RemW-1:0]  trial;
  logic                      ge;
  logic [q2e_pkg::NumW-1:0]  num_d;
  logic [q2e_pkg::RemW-1:0]  rem_d;
  logic [q2e_pkg::RootW-1:0] root_d;
  logic [q2e_pkg::NumW-1:0]  num_q;
  logic [q2e_pkg::RemW-1:0]  rem_q;
  logic [q2e_pkg::RootW-1:0] root_q;
  q2e_pkg::side_t            side_q;

  always_comb begin
    rem_sh = {rem_i[q2e_pkg::RemW-3:0], num_i[q2e_pkg::NumW-1 -: 2]};
    trial  = q2e_pkg::RemW'({root_i, 2'b01});
    ge     = rem_sh >= trial;
    rem_d  = ge ? rem_sh - trial : rem_sh;
    root_d = {root_i[q2e_pkg::RootW-2:0], ge};
    num_d  = {num_i[q2e_pkg::NumW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= num_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign num_o  = num_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign side_o = side_q;

endmodule

// File: sv/q2e_cordic_cell.sv
// One vectoring iteration of the pipelined CORDIC arctangent.
module q2e_cordic_cell (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [q2e_pkg::ShiftW-1:0]    shift_i,
  input  q2e_pkg::vec_t                 vec_i,
  output q2e_pkg::vec_t                 vec_o
);

  logic signed [q2e_pkg::CordW-1:0] xs;
  logic signed [q2e_pkg::CordW-1:0] ys;
  logic signed [q2e_pkg::AngW-1:0]  ang;
  q2e_pkg::vec_t                    vec_d;
  q2e_pkg::vec_t                    vec_q;

  always_comb begin
    xs         = vec_i.x >>> shift_i;
    ys         = vec_i.y >>> shift_i;
    ang        = q2e_pkg::atan_step(shift_i);
    vec_d.zero = vec_i.zero;
    if (!vec_i.y[q2e_pkg::CordW-1]) begin
      vec_d.x = vec_i.x + ys;
      vec_d.y = vec_i.y - xs;
      vec_d.z = vec_i.z + ang;
    end else begin
      vec_d.x = vec_i.x - ys;
      vec_d.y = vec_i.y + xs;
      vec_d.z = vec_i.z - ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign vec_o = vec_q;

endmodule

// File: sv/quaternion_to_euler_degrees_core.sv
// Quaternion to roll/pitch/yaw converter: one beat in per cycle while the output is not stalled;
// pipeline stages are multiply, sum, square, 29-cell square root row, quadrant stage, 20-cell CORDIC row,
// output register; all stages advance together and hold while the output beat is stalled.
module quaternion_to_euler_degrees_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  q2e_quat_if.sink         quat_i,
  q2e_euler_if.source      euler_o
);

  localparam int Ns = q2e_pkg::NumStages;
  localparam int Sc = q2e_pkg::SqrtCells;
  localparam int Ci = q2e_pkg::CordIters;

  logic            adv;
  logic [Ns-1:0]   valid_q;

  logic signed [q2e_pkg::ProdW-1:0] wx_q, yz_q, xx_q, yy_q, wy_q, zx_q, wz_q, xy_q, zz_q;
  q2e_pkg::side_t                   side_b_q;
  q2e_pkg::side_t                   side_c_q;
  logic [q2e_pkg::NumW-1:0]         num_c_q;
  logic signed [28:0]               s29;
  logic signed [q2e_pkg::NumW-1:0]  sq;
  q2e_pkg::side_t                   side_b_d;
  logic signed [q2e_pkg::ProdW-1:0] qw_e, qx_e, qy_e, qz_e;

  logic [q2e_pkg::NumW-1:0]   num_a  [Sc+1];
  logic [q2e_pkg::RemW-1:0]   rem_a  [Sc+1];
  logic [q2e_pkg::RootW-1:0]  root_a [Sc+1];
  q2e_pkg::side_t             side_a [Sc+1];

  q2e_pkg::vec_t roll_a  [Ci+1];
  q2e_pkg::vec_t pitch_a [Ci+1];
  q2e_pkg::vec_t yaw_a   [Ci+1];
  logic          clamp_q [Ci+1];
  logic          pos_q   [Ci+1];

  logic [q2e_pkg::OutW-1:0] roll_q, pitch_q, yaw_q;
  logic                     clamped_q;

  function automatic q2e_pkg::vec_t prerot(input q2e_pkg::term_t yv, input q2e_pkg::term_t xv);
    q2e_pkg::vec_t           v;
    logic signed [q2e_pkg::CordW-1:0] xe;
    logic signed [q2e_pkg::CordW-1:0] ye;
    xe     = q2e_pkg::CordW'(xv);
    ye     = q2e_pkg::CordW'(yv);
    v.zero = (xv == '0) && (yv == '0);
    if (xv[q2e_pkg::TermW-1] && !yv[q2e_pkg::TermW-1]) begin
      v.x = ye;
      v.y = -xe;
      v.z = q2e_pkg::Deg90;
    end else if (xv[q2e_pkg::TermW-1]) begin
      v.x = -ye;
      v.y = xe;
      v.z = q2e_pkg::Deg90N;
    end else begin
      v.x = xe;
      v.y = ye;
      v.z = '0;
    end
    return v;
  endfunction

  function automatic logic [q2e_pkg::OutW-1:0] to_deg(input q2e_pkg::vec_t v);
    logic signed [q2e_pkg::AngW:0] a;
    logic signed [17:0]            r;
    a = (q2e_pkg::AngW+1)'(v.z) + (q2e_pkg::AngW+1)'(256);
    r = 18'(a >>> 9) + 18'(23040);
    if (v.zero) begin
      return q2e_pkg::Deg180O;
    end else if (r[17]) begin
      return '0;
    end else if (r > 18'(46080)) begin
      return q2e_pkg::Deg360O;
    end else begin
      return r[q2e_pkg::OutW-1:0];
    end
  endfunction

  assign adv          = !valid_q[Ns-1] || euler_o.ready;
  assign quat_i.ready = adv;

  assign qw_e = q2e_pkg::ProdW'(quat_i.quat_w);
  assign qx_e = q2e_pkg::ProdW'(quat_i.quat_x);
  assign qy_e = q2e_pkg::ProdW'(quat_i.quat_y);
  assign qz_e = q2e_pkg::ProdW'(quat_i.quat_z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[Ns-2:0], quat_i.valid};
    end
  end

  always_comb begin
    side_b_d.sinr  = (q2e_pkg::term_t'(wx_q) + q2e_pkg::term_t'(yz_q)) <<< 1;
    side_b_d.cosr  = q2e_pkg::OneQ28 - ((q2e_pkg::term_t'(xx_q) + q2e_pkg::term_t'(yy_q)) <<< 1);
    side_b_d.sinp  = (q2e_pkg::term_t'(wy_q) - q2e_pkg::term_t'(zx_q)) <<< 1;
    side_b_d.siny  = (q2e_pkg::term_t'(wz_q) + q2e_pkg::term_t'(xy_q)) <<< 1;
    side_b_d.cosy  = q2e_pkg::OneQ28 - ((q2e_pkg::term_t'(yy_q) + q2e_pkg::term_t'(zz_q)) <<< 1);
    side_b_d.clamp = (side_b_d.sinp >= q2e_pkg::OneQ28) || (side_b_d.sinp <= -q2e_pkg::OneQ28);
    s29            = side_b_q.sinp[28:0];
    sq             = q2e_pkg::NumW'(s29) * q2e_pkg::NumW'(s29);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wx_q     <= qw_e * qx_e;
      yz_q     <= qy_e * qz_e;
      xx_q     <= qx_e * qx_e;
      yy_q     <= qy_e * qy_e;
      wy_q     <= qw_e * qy_e;
      zx_q     <= qz_e * qx_e;
      wz_q     <= qw_e * qz_e;
      xy_q     <= qx_e * qy_e;
      zz_q     <= qz_e * qz_e;
      side_b_q <= side_b_d;
      num_c_q  <= (q2e_pkg::NumW'(1) << 56) - q2e_pkg::NumW'(sq);
      side_c_q <= side_b_q;
    end
  end

  assign num_a[0]  = num_c_q;
  assign rem_a[0]  = '0;
  assign root_a[0] = '0;
  assign side_a[0] = side_c_q;

  for (genvar k = 0; k < Sc; k++) begin : g_sqrt
    q2e_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .num_i  (num_a[k]),
      .rem_i  (rem_a[k]),
      .root_i (root_a[k]),
      .side_i (side_a[k]),
      .num_o  (num_a[k+1]),
      .rem_o  (rem_a[k+1]),
      .root_o (root_a[k+1]),
      .side_o (side_a[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      roll_a[0]  <= prerot(side_a[Sc].sinr, side_a[Sc].cosr);
      pitch_a[0] <= prerot(side_a[Sc].sinp, q2e_pkg::term_t'(root_a[Sc]));
      yaw_a[0]   <= prerot(side_a[Sc].siny, side_a[Sc].cosy);
      clamp_q[0] <= side_a[Sc].clamp;
      pos_q[0]   <= !side_a[Sc].sinp[q2e_pkg::TermW-1];
    end
  end

  for (genvar i = 0; i < Ci; i++) begin : g_cordic
    q2e_cordic_cell u_roll (
      .clk_i (clk_i), .en_i (adv), .shift_i (q2e_pkg::ShiftW'(i)),
      .vec_i (roll_a[i]), .vec_o (roll_a[i+1])
    );
    q2e_cordic_cell u_pitch (
      .clk_i (clk_i), .en_i (adv), .shift_i (q2e_pkg::ShiftW'(i)),
      .vec_i (pitch_a[i]), .vec_o (pitch_a[i+1])
    );
    q2e_cordic_cell u_yaw (
      .clk_i (clk_i), .en_i (adv), .shift_i (q2e_pkg::ShiftW'(i)),
      .vec_i (yaw_a[i]), .vec_o (yaw_a[i+1])
    );
    always_ff @(posedge clk_i) begin
      if (adv) begin
        clamp_q[i+1] <= clamp_q[i];
        pos_q[i+1]   <= pos_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      roll_q    <= to_deg(roll_a[Ci]);
      yaw_q     <= to_deg(yaw_a[Ci]);
      clamped_q <= clamp_q[Ci];
      if (clamp_q[Ci]) begin
        pitch_q <= pos_q[Ci] ? q2e_pkg::Deg270O : q2e_pkg::Deg90O;
      end else begin
        pitch_q <= to_deg(pitch_a[Ci]);
      end
    end
  end

  assign euler_o.valid         = valid_q[Ns-1];
  assign euler_o.roll_deg      = roll_q;
  assign euler_o.pitch_deg     = pitch_q;
  assign euler_o.yaw_deg       = yaw_q;
  assign euler_o.pitch_clamped = clamped_q;

endmodule

// File: sv/q2e_checker.sv
// Port-level checks on the quaternion to Euler angle core, bound to the top level.
module q2e_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [q2e_pkg::OutW-1:0] roll_i,
  input logic [q2e_pkg::OutW-1:0] pitch_i,
  input logic [q2e_pkg::OutW-1:0] yaw_i,
  input logic                     clamped_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(roll_i) && $stable(pitch_i))
    else $error("output beat dropped while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i || out_ready_i |-> in_ready_i)
    else $error("input stalled with free output stage");

  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && clamped_i |->
      pitch_i == q2e_pkg::Deg270O || pitch_i == q2e_pkg::Deg90O)
    else $error("clamped pitch not at 90 degrees");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> roll_i <= q2e_pkg::Deg360O && yaw_i <= q2e_pkg::Deg360O
      && pitch_i <= q2e_pkg::Deg270O && pitch_i >= q2e_pkg::Deg90O)
    else $error("angle out of range");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while output stalled");

endmodule

bind quaternion_to_euler_degrees_core q2e_checker u_q2e_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (quat_i.valid),
  .in_ready_i  (quat_i.ready),
  .out_valid_i (euler_o.valid),
  .out_ready_i (euler_o.ready),
  .roll_i      (euler_o.roll_deg),
  .pitch_i     (euler_o.pitch_deg),
  .yaw_i       (euler_o.yaw_deg),
  .clamped_i   (euler_o.pitch_clamped)
);
